// ----- rtl/nnpd_pkg.sv -----
package nnpd_pkg;

	localparam int MAX_DIM   = 16384;
	localparam int DIM_W     = 15;
	localparam int COORD_W   = 14;
	localparam int PIXEL_W   = 32;
	localparam int THR_W     = 29;
	localparam int PROD_W    = 2 * DIM_W;
	localparam int NUM_W     = 30;
	localparam int DEN_W     = DIM_W + 1;
	localparam int TGT_W     = DIM_W + 1;
	localparam int REM_W     = DEN_W;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = THR_W;
	localparam int DIV_STEPS = NUM_W;
	localparam int STEP_W    = $clog2(DIV_STEPS);

	localparam logic [DIM_W-1:0] DIM_MAX_VAL   = DIM_W'(MAX_DIM);
	localparam logic [DIM_W-1:0] RST_WIDTH     = DIM_W'(1);
	localparam logic [DIM_W-1:0] RST_HEIGHT    = DIM_W'(1);
	localparam logic [DIM_W-1:0] RST_MAX_SIDE  = DIM_W'(1536);
	localparam logic [THR_W-1:0] RST_THRESHOLD = THR_W'(25000000);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SOURCE_WIDTH    = 2'd0,
		REG_SOURCE_HEIGHT   = 2'd1,
		REG_MAX_LONG_SIDE   = 2'd2,
		REG_PIXEL_THRESHOLD = 2'd3
	} cfg_reg_t;

	// which quotient the shared divider is producing
	typedef enum logic [1:0] {
		OP_PW  = 2'd0,
		OP_PH  = 2'd1,
		OP_COL = 2'd2,
		OP_ROW = 2'd3
	} div_op_t;

	typedef struct packed {
		logic    clamp;
		logic    prod;
		logic    prep;
		logic    div_load;
		logic    div_step;
		logic    div_store;
		logic    frame_init;
		logic    run;
		div_op_t div_op;
	} ctrl_cmd_t;

	typedef struct packed {
		logic div_done;
	} dp_status_t;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] r;
		if (v == '0) begin
			r = DIM_W'(1);
		end else if (v > DIM_MAX_VAL) begin
			r = DIM_MAX_VAL;
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

// ----- rtl/nnpd_div.sv -----
module nnpd_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        load,
	input  logic                        step,
	input  logic [nnpd_pkg::NUM_W-1:0]  dividend,
	input  logic [nnpd_pkg::DEN_W-1:0]  divisor,
	output logic [nnpd_pkg::NUM_W-1:0]  quotient,
	output logic [nnpd_pkg::DEN_W-1:0]  remainder,
	output logic                        done
);
	import nnpd_pkg::*;

	logic [NUM_W-1:0]  quo_q;
	logic [DEN_W-1:0]  rem_q;
	logic [DEN_W-1:0]  div_q;
	logic [STEP_W-1:0] cnt_q;
	logic [DEN_W:0]    trial;
	logic [DEN_W:0]    diff;
	logic              ge;

	assign trial = {rem_q, quo_q[NUM_W-1]};
	assign ge    = trial >= {1'b0, div_q};
	assign diff  = trial - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= STEP_W'(DIV_STEPS - 1);
		end else if (step && cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// restoring division, one quotient bit per cycle while step is high
	always_ff @(posedge clk) begin
		if (load) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (step) begin
			quo_q <= {quo_q[NUM_W-2:0], ge};
			rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
		end
	end

	assign quotient  = quo_q;
	assign remainder = rem_q;
	assign done      = (cnt_q == '0);

endmodule

// ----- rtl/nnpd_ctrl.sv -----
module nnpd_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_write_en,
	input  nnpd_pkg::dp_status_t   status,
	output nnpd_pkg::ctrl_cmd_t    cmd
);
	import nnpd_pkg::*;

	typedef enum logic [7:0] {
		ST_CLAMP = 8'b0000_0001,
		ST_PROD  = 8'b0000_0010,
		ST_PREP  = 8'b0000_0100,
		ST_LOAD  = 8'b0000_1000,
		ST_STEP  = 8'b0001_0000,
		ST_STORE = 8'b0010_0000,
		ST_INIT  = 8'b0100_0000,
		ST_RUN   = 8'b1000_0000
	} state_t;

	state_t  state_q, state_d;
	div_op_t op_q, op_d, op_next;

	always_comb begin
		unique case (op_q)
			OP_PW:   op_next = OP_PH;
			OP_PH:   op_next = OP_COL;
			OP_COL:  op_next = OP_ROW;
			OP_ROW:  op_next = OP_PW;
			default: op_next = OP_PW;
		endcase
	end

	always_comb begin
		state_d = state_q;
		op_d    = op_q;
		priority if (cfg_write_en) begin
			state_d = ST_CLAMP;
		end else begin
			unique case (state_q)
				ST_CLAMP: state_d = ST_PROD;
				ST_PROD:  state_d = ST_PREP;
				ST_PREP: begin
					state_d = ST_LOAD;
					op_d    = OP_PW;
				end
				ST_LOAD:  state_d = ST_STEP;
				ST_STEP: begin
					if (status.div_done) begin
						state_d = ST_STORE;
					end
				end
				ST_STORE: begin
					if (op_q == OP_ROW) begin
						state_d = ST_INIT;
					end else begin
						state_d = ST_LOAD;
						op_d    = op_next;
					end
				end
				ST_INIT:  state_d = ST_RUN;
				ST_RUN:   state_d = ST_RUN;
				default:  state_d = ST_CLAMP;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLAMP;
			op_q    <= OP_PW;
		end else begin
			state_q <= state_d;
			op_q    <= op_d;
		end
	end

	always_comb begin
		cmd            = '0;
		cmd.div_op     = op_q;
		cmd.clamp      = (state_q == ST_CLAMP);
		cmd.prod       = (state_q == ST_PROD);
		cmd.prep       = (state_q == ST_PREP);
		cmd.div_load   = (state_q == ST_LOAD);
		cmd.div_step   = (state_q == ST_STEP);
		cmd.div_store  = (state_q == ST_STORE);
		cmd.frame_init = (state_q == ST_INIT);
		cmd.run        = (state_q == ST_RUN) && !cfg_write_en;
	end

endmodule

// ----- rtl/nnpd_dp.sv -----
module nnpd_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  nnpd_pkg::ctrl_cmd_t           cmd,
	output nnpd_pkg::dp_status_t          status,
	input  logic                          cfg_write_en,
	input  logic [nnpd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [nnpd_pkg::CFG_W-1:0]    cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [nnpd_pkg::PIXEL_W-1:0]  pixel_value,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [nnpd_pkg::PIXEL_W-1:0]  pixel_value_out,
	output logic                          last_in_row,
	output logic                          last_in_frame,
	output logic                          preview_active
);
	import nnpd_pkg::*;

	typedef struct packed {
		logic [TGT_W-1:0] t;
		logic [REM_W-1:0] r;
	} axis_pos_t;

	function automatic axis_pos_t advance(input logic [TGT_W-1:0] t,
		input logic [REM_W-1:0] r, input logic [TGT_W-1:0] sq,
		input logic [REM_W-1:0] sr, input logic [DEN_W-1:0] den);
		axis_pos_t        p;
		logic [REM_W:0]   sum;
		sum = {1'b0, r} + {1'b0, sr};
		if (sum >= {1'b0, den}) begin
			p.r = REM_W'(sum - {1'b0, den});
			p.t = t + sq + 1'b1;
		end else begin
			p.r = sum[REM_W-1:0];
			p.t = t + sq;
		end
		return p;
	endfunction

	// configuration registers
	logic [DIM_W-1:0] width_q, height_q, max_side_q;
	logic [THR_W-1:0] thr_q;

	// frame setup values
	logic [DIM_W-1:0]  eff_w_q, eff_h_q, eff_m_q, longest_q;
	logic [PROD_W-1:0] wh_q, wm_q, hm_q;
	logic [NUM_W-1:0]  num_w_q, num_h_q;
	logic [DEN_W-1:0]  den_l_q;
	logic              reducing_q;
	logic [DIM_W-1:0]  pw_q, ph_q;
	logic [DEN_W-1:0]  col_den_q, row_den_q;
	logic [TGT_W-1:0]  col_t0_q, row_t0_q, col_sq_q, row_sq_q;
	logic [REM_W-1:0]  col_r0_q, row_r0_q, col_sr_q, row_sr_q;

	// frame position
	logic [COORD_W-1:0] src_col_q, src_row_q, out_col_q;
	logic [DIM_W-1:0]   out_row_q;
	logic [TGT_W-1:0]   tgt_col_q, tgt_row_q;
	logic [REM_W-1:0]   col_rem_q, row_rem_q;

	// output register
	logic               out_valid_q;
	logic [PIXEL_W-1:0] pix_q;
	logic               row_last_q, frame_last_q, active_q;

	// divider hookup
	logic [NUM_W-1:0] div_dividend;
	logic [DEN_W-1:0] div_divisor;
	logic [NUM_W-1:0] div_quo;
	logic [DEN_W-1:0] div_rem;
	logic             div_done;
	logic [DEN_W-1:0] axis_den;
	logic [DIM_W-1:0] side_q;
	logic [DEN_W:0]   rem_x2;
	logic             rem_wrap;
	logic [TGT_W-1:0] step_q;
	logic [REM_W-1:0] step_r;

	// per item signals
	logic             accept;
	logic [DIM_W-1:0] w_last, h_last, pw_last, ph_last;
	logic [TGT_W-1:0] tc, tr;
	logic             row_end, frame_end, hit, emit, orow_end;
	axis_pos_t        col_next, row_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q    <= RST_WIDTH;
			height_q   <= RST_HEIGHT;
			max_side_q <= RST_MAX_SIDE;
			thr_q      <= RST_THRESHOLD;
		end else if (cfg_write_en) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_SOURCE_WIDTH:    width_q    <= cfg_data[DIM_W-1:0];
				REG_SOURCE_HEIGHT:   height_q   <= cfg_data[DIM_W-1:0];
				REG_MAX_LONG_SIDE:   max_side_q <= cfg_data[DIM_W-1:0];
				REG_PIXEL_THRESHOLD: thr_q      <= cfg_data[THR_W-1:0];
				default: ;
			endcase
		end
	end

	// divider operand selection
	assign axis_den = (cmd.div_op == OP_COL) ? {pw_q, 1'b0} : {ph_q, 1'b0};
	assign side_q   = (cmd.div_op == OP_COL) ? eff_w_q : eff_h_q;

	always_comb begin
		unique case (cmd.div_op)
			OP_PW: begin
				div_dividend = num_w_q;
				div_divisor  = den_l_q;
			end
			OP_PH: begin
				div_dividend = num_h_q;
				div_divisor  = den_l_q;
			end
			OP_COL, OP_ROW: begin
				div_dividend = NUM_W'(side_q);
				div_divisor  = axis_den;
			end
			default: begin
				div_dividend = num_w_q;
				div_divisor  = den_l_q;
			end
		endcase
	end

	nnpd_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (cmd.div_load),
		.step      (cmd.div_step),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.quotient  (div_quo),
		.remainder (div_rem),
		.done      (div_done)
	);

	assign status.div_done = div_done;

	// step of 2*side over den, derived from side / den
	assign rem_x2   = {div_rem, 1'b0};
	assign rem_wrap = rem_x2 >= {1'b0, axis_den};
	assign step_q   = TGT_W'({div_quo, 1'b0}) + TGT_W'(rem_wrap);
	assign step_r   = rem_wrap ? REM_W'(rem_x2 - {1'b0, axis_den}) : rem_x2[REM_W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.clamp) begin
			eff_w_q <= clamp_dim(width_q);
			eff_h_q <= clamp_dim(height_q);
			eff_m_q <= clamp_dim(max_side_q);
		end
		if (cmd.prod) begin
			wh_q      <= PROD_W'(eff_w_q) * PROD_W'(eff_h_q);
			wm_q      <= PROD_W'(eff_w_q) * PROD_W'(eff_m_q);
			hm_q      <= PROD_W'(eff_h_q) * PROD_W'(eff_m_q);
			longest_q <= (eff_w_q > eff_h_q) ? eff_w_q : eff_h_q;
		end
		if (cmd.prep) begin
			reducing_q <= (wh_q >= PROD_W'(thr_q)) && (longest_q > eff_m_q);
			num_w_q    <= NUM_W'({wm_q, 1'b0}) + NUM_W'(longest_q);
			num_h_q    <= NUM_W'({hm_q, 1'b0}) + NUM_W'(longest_q);
			den_l_q    <= {longest_q, 1'b0};
		end
		if (cmd.div_store) begin
			unique case (cmd.div_op)
				OP_PW: begin
					if (!reducing_q) begin
						pw_q <= eff_w_q;
					end else if (div_quo == '0) begin
						pw_q <= DIM_W'(1);
					end else begin
						pw_q <= div_quo[DIM_W-1:0];
					end
				end
				OP_PH: begin
					if (!reducing_q) begin
						ph_q <= eff_h_q;
					end else if (div_quo == '0) begin
						ph_q <= DIM_W'(1);
					end else begin
						ph_q <= div_quo[DIM_W-1:0];
					end
				end
				OP_COL: begin
					col_den_q <= axis_den;
					col_t0_q  <= div_quo[TGT_W-1:0];
					col_r0_q  <= div_rem;
					col_sq_q  <= step_q;
					col_sr_q  <= step_r;
				end
				OP_ROW: begin
					row_den_q <= axis_den;
					row_t0_q  <= div_quo[TGT_W-1:0];
					row_r0_q  <= div_rem;
					row_sq_q  <= step_q;
					row_sr_q  <= step_r;
				end
				default: ;
			endcase
		end
	end

	// item path
	assign accept    = in_valid && !in_stall;
	assign in_stall  = !(cmd.run && (!out_valid_q || !out_stall));
	assign w_last    = eff_w_q - 1'b1;
	assign h_last    = eff_h_q - 1'b1;
	assign pw_last   = pw_q - 1'b1;
	assign ph_last   = ph_q - 1'b1;
	assign tc        = (tgt_col_q < TGT_W'(w_last)) ? tgt_col_q : TGT_W'(w_last);
	assign tr        = (tgt_row_q < TGT_W'(h_last)) ? tgt_row_q : TGT_W'(h_last);
	assign row_end   = (DIM_W'(src_col_q) == w_last);
	assign frame_end = row_end && (DIM_W'(src_row_q) == h_last);
	assign hit       = (TGT_W'(src_col_q) == tc) && (TGT_W'(src_row_q) == tr)
		&& (out_row_q < ph_q);
	assign emit      = !reducing_q || hit;
	assign orow_end  = (DIM_W'(out_col_q) == pw_last);
	assign col_next  = advance(tgt_col_q, col_rem_q, col_sq_q, col_sr_q, col_den_q);
	assign row_next  = advance(tgt_row_q, row_rem_q, row_sq_q, row_sr_q, row_den_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_col_q <= '0;
			src_row_q <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			tgt_col_q <= '0;
			tgt_row_q <= '0;
			col_rem_q <= '0;
			row_rem_q <= '0;
		end else if (cmd.frame_init || (accept && frame_end)) begin
			// restart the frame from the stored setup
			src_col_q <= '0;
			src_row_q <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			tgt_col_q <= col_t0_q;
			tgt_row_q <= row_t0_q;
			col_rem_q <= col_r0_q;
			row_rem_q <= row_r0_q;
		end else if (accept) begin
			if (row_end) begin
				src_col_q <= '0;
				src_row_q <= src_row_q + 1'b1;
			end else begin
				src_col_q <= src_col_q + 1'b1;
			end
			if (reducing_q && hit) begin
				if (orow_end) begin
					out_col_q <= '0;
					out_row_q <= out_row_q + 1'b1;
					tgt_col_q <= col_t0_q;
					col_rem_q <= col_r0_q;
					tgt_row_q <= row_next.t;
					row_rem_q <= row_next.r;
				end else begin
					out_col_q <= out_col_q + 1'b1;
					tgt_col_q <= col_next.t;
					col_rem_q <= col_next.r;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= emit;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && emit) begin
			pix_q        <= pixel_value;
			active_q     <= reducing_q;
			row_last_q   <= reducing_q ? orow_end : row_end;
			frame_last_q <= reducing_q ? (orow_end && (out_row_q == ph_last)) : frame_end;
		end
	end

	assign out_valid       = out_valid_q;
	assign pixel_value_out = pix_q;
	assign last_in_row     = row_last_q;
	assign last_in_frame   = frame_last_q;
	assign preview_active  = active_q;

endmodule

// ----- rtl/nearest_neighbor_preview_downscaler_core.sv -----
// Channel   Handshake             Payload
// config    cfg_write_en          cfg_index, cfg_data
// pixels in in_valid / in_stall   pixel_value
// pixels out out_valid / out_stall pixel_value_out, last_in_row, last_in_frame, preview_active
//
// Once set up, one item per cycle unless stalled; each item yields zero or one result.
// Frame setup runs a shared bit-serial divider four times after reset and
// after every register write, with in_stall held high.
// Frame wrap reuses the stored setup and does not stall the input.
// A single output register sits between the sides; in_stall rises when it is
// full and out_stall is high, and during a register write and frame setup.
module nearest_neighbor_preview_downscaler_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_write_en,
	input  logic [nnpd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [nnpd_pkg::CFG_W-1:0]     cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [nnpd_pkg::PIXEL_W-1:0]   pixel_value,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [nnpd_pkg::PIXEL_W-1:0]   pixel_value_out,
	output logic                           last_in_row,
	output logic                           last_in_frame,
	output logic                           preview_active
);
	import nnpd_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t status;

	nnpd_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write_en (cfg_write_en),
		.status       (status),
		.cmd          (cmd)
	);

	nnpd_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.status          (status),
		.cfg_write_en    (cfg_write_en),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.pixel_value     (pixel_value),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.pixel_value_out (pixel_value_out),
		.last_in_row     (last_in_row),
		.last_in_frame   (last_in_frame),
		.preview_active  (preview_active)
	);

endmodule

// ----- dv/downscale_checker.sv -----
`timescale 1ns / 1ps

module downscale_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_write_en,
	input  logic [nnpd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [nnpd_pkg::CFG_W-1:0]     cfg_data,
	input  logic                           in_valid,
	input  logic                           in_stall,
	input  logic [nnpd_pkg::PIXEL_W-1:0]   pixel_value,
	input  logic                           out_valid,
	input  logic                           out_stall,
	input  logic [nnpd_pkg::PIXEL_W-1:0]   pixel_value_out,
	input  logic                           last_in_row,
	input  logic                           last_in_frame,
	input  logic                           preview_active,
	output int unsigned                    failures,
	output int unsigned                    pending
);
	import nnpd_pkg::*;

	typedef struct packed {
		logic [PIXEL_W-1:0] pixel;
		logic               row_last;
		logic               frame_last;
		logic               active;
	} kept_pixel_t;

	kept_pixel_t expected_pixels[$];

	// register copies
	logic [DIM_W-1:0] reg_width, reg_height, reg_max_side;
	logic [THR_W-1:0] reg_threshold;

	// per-frame setup
	logic [DIM_W-1:0] eff_w, eff_h, prv_w, prv_h;
	logic             reduce;
	logic [DEN_W-1:0] col_den, row_den;
	logic [TGT_W-1:0] col_t0, row_t0, col_q, row_q;
	logic [REM_W-1:0] col_r0, row_r0, col_sr, row_sr;

	// position in source and preview frame
	logic [DIM_W-1:0] sx, sy, ox, oy;
	logic [TGT_W-1:0] tgt_x, tgt_y;
	logic [REM_W-1:0] rem_x, rem_y;

	function automatic logic [DIM_W-1:0] fit_dim(input logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] r;
		r = v;
		if (r > DIM_W'(MAX_DIM)) r = DIM_W'(MAX_DIM);
		if (r == '0) r = DIM_W'(1);
		return r;
	endfunction

	// round-half-up of side*m/longest, never below one
	function automatic logic [DIM_W-1:0] shrunk_side(input longint unsigned side, m, longest);
		longint unsigned v;
		v = (2 * side * m + longest) / (2 * longest);
		return (v == 0) ? DIM_W'(1) : DIM_W'(v);
	endfunction

	function automatic logic [TGT_W+REM_W-1:0] next_target(
		input logic [TGT_W-1:0] t,
		input logic [REM_W-1:0] r,
		input logic [TGT_W-1:0] q,
		input logic [REM_W-1:0] sr,
		input logic [DEN_W-1:0] den
	);
		logic [REM_W:0]   sum;
		logic [TGT_W-1:0] tn;
		sum = {1'b0, r} + {1'b0, sr};
		tn = t + q;
		if (sum >= {1'b0, den}) begin
			sum = sum - {1'b0, den};
			tn = tn + 1'b1;
		end
		return {tn, sum[REM_W-1:0]};
	endfunction

	function automatic void restart_frame();
		longint unsigned m, longest, cw, ch;
		m = fit_dim(reg_max_side);
		eff_w = fit_dim(reg_width);
		eff_h = fit_dim(reg_height);
		cw = eff_w;
		ch = eff_h;
		longest = (cw > ch) ? cw : ch;
		reduce = (cw * ch >= reg_threshold) && (longest > m);
		prv_w = reduce ? shrunk_side(cw, m, longest) : eff_w;
		prv_h = reduce ? shrunk_side(ch, m, longest) : eff_h;
		col_den = {prv_w, 1'b0};
		row_den = {prv_h, 1'b0};
		col_t0 = TGT_W'(cw / col_den);
		col_r0 = REM_W'(cw % col_den);
		col_q = TGT_W'((2 * cw) / col_den);
		col_sr = REM_W'((2 * cw) % col_den);
		row_t0 = TGT_W'(ch / row_den);
		row_r0 = REM_W'(ch % row_den);
		row_q = TGT_W'((2 * ch) / row_den);
		row_sr = REM_W'((2 * ch) % row_den);
		sx = '0;
		sy = '0;
		ox = '0;
		oy = '0;
		tgt_x = col_t0;
		rem_x = col_r0;
		tgt_y = row_t0;
		rem_y = row_r0;
	endfunction

	function automatic void predict_pixel(input logic [PIXEL_W-1:0] pix);
		logic             row_end, frame_end, orow_end;
		logic [TGT_W-1:0] tc, tr;
		kept_pixel_t      r;
		row_end = (sx == eff_w - 1'b1);
		frame_end = row_end && (sy == eff_h - 1'b1);
		tc = (tgt_x < eff_w - 1'b1) ? tgt_x : TGT_W'(eff_w - 1'b1);
		tr = (tgt_y < eff_h - 1'b1) ? tgt_y : TGT_W'(eff_h - 1'b1);
		r.pixel = pix;
		if (!reduce) begin
			r.row_last = row_end;
			r.frame_last = frame_end;
			r.active = 1'b0;
			expected_pixels.push_back(r);
		end else if (oy < prv_h && sx == tc && sy == tr) begin
			orow_end = (ox == prv_w - 1'b1);
			r.row_last = orow_end;
			r.frame_last = orow_end && (oy == prv_h - 1'b1);
			r.active = 1'b1;
			expected_pixels.push_back(r);
			if (orow_end) begin
				ox = '0;
				tgt_x = col_t0;
				rem_x = col_r0;
				oy = oy + 1'b1;
				{tgt_y, rem_y} = next_target(tgt_y, rem_y, row_q, row_sr, row_den);
			end else begin
				ox = ox + 1'b1;
				{tgt_x, rem_x} = next_target(tgt_x, rem_x, col_q, col_sr, col_den);
			end
		end
		if (frame_end) begin
			restart_frame();
		end else if (row_end) begin
			sx = '0;
			sy = sy + 1'b1;
		end else begin
			sx = sx + 1'b1;
		end
	endfunction

	function automatic void compare_field(input string what, input logic [PIXEL_W-1:0] want,
		input logic [PIXEL_W-1:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
			failures++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		kept_pixel_t e;
		if (!arst_n) begin
			reg_width = RST_WIDTH;
			reg_height = RST_HEIGHT;
			reg_max_side = RST_MAX_SIDE;
			reg_threshold = RST_THRESHOLD;
			restart_frame();
			expected_pixels.delete();
			failures = 0;
		end else begin
			if (cfg_write_en) begin
				case (cfg_index)
					REG_SOURCE_WIDTH:    reg_width = cfg_data[DIM_W-1:0];
					REG_SOURCE_HEIGHT:   reg_height = cfg_data[DIM_W-1:0];
					REG_MAX_LONG_SIDE:   reg_max_side = cfg_data[DIM_W-1:0];
					REG_PIXEL_THRESHOLD: reg_threshold = cfg_data[THR_W-1:0];
					default: ;
				endcase
				restart_frame();
			end
			if (in_valid && !in_stall) predict_pixel(pixel_value);
			if (out_valid && !out_stall) begin
				if (expected_pixels.size() == 0) begin
					$display("%0t: unexpected pixel, expected none, got %0h", $time,
						pixel_value_out);
					failures++;
				end else begin
					e = expected_pixels.pop_front();
					compare_field("pixel_value_out", e.pixel, pixel_value_out);
					compare_field("last_in_row", PIXEL_W'(e.row_last), PIXEL_W'(last_in_row));
					compare_field("last_in_frame", PIXEL_W'(e.frame_last),
						PIXEL_W'(last_in_frame));
					compare_field("preview_active", PIXEL_W'(e.active),
						PIXEL_W'(preview_active));
				end
			end
		end
		pending = expected_pixels.size();
	end

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
	import nnpd_pkg::*;

	localparam int LIMIT_CYCLES  = 400000;
	localparam int HOLD_CYCLES   = 300;
	localparam int SETTLE_CYCLES = 16;
	localparam int STIM_ITEMS    = 700;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_write_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	logic                 in_valid;
	logic                 in_stall;
	logic [PIXEL_W-1:0]   pixel_value;
	logic                 out_valid;
	logic                 out_stall;
	logic [PIXEL_W-1:0]   pixel_value_out;
	logic                 last_in_row;
	logic                 last_in_frame;
	logic                 preview_active;

	int unsigned failures, pending;
	int unsigned idle_pct, stall_pct, items_sent, phase_no;
	logic        hold_req;

	nearest_neighbor_preview_downscaler_core dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write_en   (cfg_write_en),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.pixel_value    (pixel_value),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.pixel_value_out(pixel_value_out),
		.last_in_row    (last_in_row),
		.last_in_frame  (last_in_frame),
		.preview_active (preview_active)
	);

	downscale_checker checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write_en   (cfg_write_en),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.pixel_value    (pixel_value),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.pixel_value_out(pixel_value_out),
		.last_in_row    (last_in_row),
		.last_in_frame  (last_in_frame),
		.preview_active (preview_active),
		.failures       (failures),
		.pending        (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin : watchdog
		int unsigned cycles;
		cycles = 0;
		while (cycles < LIMIT_CYCLES) begin
			@(posedge clk);
			cycles++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	// output side: random stalls, plus one long hold-off on request
	initial begin : receiver
		bit held_off;
		held_off = 1'b0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req && !held_off) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				held_off = 1'b1;
			end
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	task automatic set_idling(input int unsigned mode);
		case (mode % 4)
			0: begin idle_pct = 0;  stall_pct = 0;  end
			1: begin idle_pct = 58; stall_pct = 0;  end
			2: begin idle_pct = 0;  stall_pct = 58; end
			default: begin idle_pct = 25; stall_pct = 25; end
		endcase
	endtask

	task automatic send_pixel(input logic [PIXEL_W-1:0] v);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		pixel_value <= v;
		do @(posedge clk); while (in_stall);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_random(input int unsigned n);
		repeat (n) send_pixel($urandom());
	endtask

	// drop valid and drain every expected pixel
	task automatic drain();
		in_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
		cfg_write_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_write_en <= 1'b0;
		@(negedge clk);
		// frame setup holds the input side closed
		while (in_stall) @(negedge clk);
	endtask

	task automatic configure_frame(input int unsigned w, h, m, thr);
		drain();
		repeat (SETTLE_CYCLES) @(negedge clk);
		write_reg(REG_SOURCE_WIDTH, CFG_W'(w));
		write_reg(REG_SOURCE_HEIGHT, CFG_W'(h));
		write_reg(REG_MAX_LONG_SIDE, CFG_W'(m));
		write_reg(REG_PIXEL_THRESHOLD, CFG_W'(thr));
		phase_no++;
		set_idling(phase_no);
	endtask

	initial begin : stimulus
		int unsigned w, h, m, thr, longest;
		cfg_write_en = 1'b0;
		cfg_index = REG_SOURCE_WIDTH;
		cfg_data = '0;
		in_valid = 1'b0;
		pixel_value = '0;
		hold_req = 1'b0;
		items_sent = 0;
		phase_no = 0;
		set_idling(0);
		arst_n = 1'b0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		// reset setup: 1x1 frames, every pixel is a whole frame
		send_pixel('0);
		send_pixel('1);
		// pixel count exactly at threshold: 5x4 reduced to 2x2
		configure_frame(5, 4, 2, 20);
		send_random(20);

		// zero registers count as one
		configure_frame(0, 0, 0, 0);
		send_random(10);
		// oversized width clamps; preview height rounds half up to one
		configure_frame('h7FFF, 1, 8192, 0);
		send_random(80);
		// longest side equal to the limit passes through; fill up during hold-off
		configure_frame(7, 9, 9, 0);
		hold_req = 1'b1;
		send_random(70);
		// one pixel short of the threshold
		configure_frame(7, 9, 8, 64);
		send_random(63);
		// reduced to 6x8 over two frames, drained near the end of the first
		configure_frame(7, 9, 8, 63);
		send_random(60);
		drain();
		send_random(66);
		// widest max-side and threshold register values
		configure_frame(5, 3, 'h7FFF, 'h1FFFFFFF);
		send_random(40);
		// single preview pixel per frame, rest of frame dropped
		configure_frame(9, 3, 1, 0);
		send_random(54);

		while (items_sent < STIM_ITEMS) begin
			w = $urandom_range(1, 12);
			h = $urandom_range(1, 12);
			longest = (w > h) ? w : h;
			m = $urandom_range(1, longest);
			case ($urandom_range(0, 5))
				0: thr = w * h + 1;
				1: thr = $urandom_range(0, 'h1FFFFFFF);
				2: thr = w * h;
				default: thr = $urandom_range(0, w * h);
			endcase
			configure_frame(w, h, m, thr);
			// whole frames, then a partial one, if any, cut off by the next write
			send_random(w * h * $urandom_range(1, 2) + $urandom_range(0, w * h - 1));
		end

		drain();
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (failures == 0 && pending == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
